[rtl/core/subtractive_lagged_random_generator_unit_defines.svh]
// Assertion macros included by the generator's top-level RTL file.
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SLRG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slrg: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SLRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slrg: next-cycle check failed");
`else
`define SLRG_ASSERT_SAME(lbl, ante, cons)
`define SLRG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/slrg_pkg.sv]
// Shared constants, types and helper functions of the subtractive generator.
`default_nettype none

package slrg_pkg;

	localparam int unsigned TblDepth      = 55;
	localparam int unsigned TblAw         = 6;
	localparam int unsigned ValW          = 31;
	localparam int unsigned SeedW         = 32;
	localparam int unsigned CfgIdxW       = 1;
	localparam int unsigned ScatterStride = 21;
	localparam int unsigned WarmLag       = 31;
	localparam int unsigned WarmPasses    = 4;
	localparam int unsigned WarmPassW     = $clog2(WarmPasses);
	localparam int unsigned LagStart      = 31;
	localparam int unsigned DivSteps      = SeedW;
	localparam int unsigned DivCntW       = $clog2(DivSteps);

	localparam logic [ValW-1:0] ModulusReset    = 31'd1000000000;
	localparam logic [ValW-1:0] SeedOffsetReset = 31'd161803398;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_MODULUS     = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_SEED_OFFSET = 1'b1;

	typedef logic [TblAw-1:0] tbl_addr_t;
	typedef logic [ValW-1:0]  val_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCATTER,
		ST_WARM,
		ST_DRAW_RD,
		ST_DRAW_WB
	} state_t;

	typedef struct packed {
		logic      en;
		tbl_addr_t addr_a;
		tbl_addr_t addr_b;
	} tbl_rd_t;

	typedef struct packed {
		logic      en;
		tbl_addr_t addr;
		val_t      data;
	} tbl_wr_t;

	typedef struct packed {
		logic             done;
		logic [SeedW-1:0] rem;
	} mod_stat_t;

	// a - b, plus the modulus when negative; kept to 31 bits
	function automatic val_t wrap_sub(val_t a, val_t b, logic [SeedW-1:0] m);
		logic signed [SeedW:0] d;
		d = $signed({2'b00, a}) - $signed({2'b00, b});
		if (d < 0) begin
			d = d + $signed({1'b0, m});
		end
		return d[ValW-1:0];
	endfunction

	// ring pointer runs 1..55, wraps back to 1
	function automatic tbl_addr_t ptr_next(tbl_addr_t p);
		return (p >= TblAw'(TblDepth)) ? TblAw'(1) : p + TblAw'(1);
	endfunction

endpackage

`default_nettype wire

[rtl/core/slrg_table.sv]
// 55-entry lag table: two registered read ports, one write port.
`default_nettype none

module slrg_table (
	input  wire logic             clk,
	input  wire slrg_pkg::tbl_rd_t rd,
	input  wire slrg_pkg::tbl_wr_t wr,
	output logic [slrg_pkg::ValW-1:0] rd_data_a,
	output logic [slrg_pkg::ValW-1:0] rd_data_b
);
	import slrg_pkg::*;

	val_t mem [0:TblDepth-1];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_a <= mem[rd.addr_a];
			rd_data_b <= mem[rd.addr_b];
		end
	end

endmodule

`default_nettype wire

[rtl/core/slrg_mod_unit.sv]
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
`default_nettype none

module slrg_mod_unit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [slrg_pkg::SeedW-1:0] dividend,
	input  wire logic [slrg_pkg::SeedW-1:0] divisor,
	output slrg_pkg::mod_stat_t           stat
);
	import slrg_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [SeedW-1:0]   dvd_q;
	logic [SeedW-1:0]   dvs_q;
	logic [SeedW-1:0]   rem_q;
	logic [SeedW:0]     trial;
	logic [SeedW-1:0]   rem_nxt;

	// restoring step; rem stays below divisor so trial fits 33 bits
	always_comb begin
		trial = {rem_q, dvd_q[SeedW-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = SeedW'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = trial[SeedW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DivCntW'(1);
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SeedW-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/subtractive_lagged_random_generator_unit.sv]
// Top level of the subtractive lagged-Fibonacci random generator.
// Each input transfer carries a 32-bit signed seed and yields exactly one
// output transfer: a 31-bit value in m_tdata[30:0] and, in m_tuser, a flag
// that is set when that request rebuilt the generator table. The table is
// rebuilt when the seed is negative or on the first request after reset;
// otherwise the seed is ignored. In a normal draw the accept cycle issues
// both table reads; ST_DRAW_WB then subtracts, wraps and writes back once
// the output register has room. A rebuild runs through the bit-serial
// remainder unit, 54 scatter writes, 220 warm-up steps (four passes of
// 55, one table update per cycle) and the draw itself. No input is taken
// during a rebuild. The output sits in a register, so a new request is
// accepted while the previous result still waits on m_tready.
// Configuration (index 0: modulus, index 1: seed offset) is always ready
// and must only be written while the block is idle. A modulus of zero acts
// as 2^31.
`default_nettype none
`include "subtractive_lagged_random_generator_unit_defines.svh"

module subtractive_lagged_random_generator_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// seed request stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [slrg_pkg::SeedW-1:0]    s_tdata,   // [31:0] seed_word
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [slrg_pkg::SeedW-1:0]         m_tdata,   // [30:0] random_value, [31] zero
	output logic                               m_tuser,   // [0] reseeded
	// configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [slrg_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [slrg_pkg::ValW-1:0]     cfg_data
);
	import slrg_pkg::*;

	// config registers
	val_t             modulus_q;
	val_t             seed_offset_q;
	logic [SeedW-1:0] m_eff;

	// control state
	state_t    state_q, state_nxt;
	tbl_addr_t rp_q, lp_q;
	logic      seeded_q;
	logic      reseed_q;

	// rebuild datapath
	val_t                 mj_q, mk_q;
	tbl_addr_t            pos_q;
	tbl_addr_t            scat_cnt_q;
	tbl_addr_t            widx_q;
	logic [WarmPassW-1:0] pass_q;
	logic                 warm_s1;
	tbl_addr_t            waddr_s1;

	// output register
	logic out_valid_q;
	val_t out_value_q;
	logic out_reseed_q;

	// handshake and seed decode
	logic             s_xfer;
	logic             seed_neg;
	logic             need_seed;
	logic [SeedW-1:0] seed_mag;
	logic [SeedW:0]   seed_diff;
	logic [SeedW-1:0] seed_abs;
	logic             out_free;

	// table and remainder unit hookup
	tbl_rd_t   tbl_rd;
	tbl_wr_t   tbl_wr;
	val_t      rd_a, rd_b;
	val_t      tbl_diff;
	mod_stat_t mod_stat;

	// scatter / warm-up address steps
	logic [TblAw:0] pos_sum;
	tbl_addr_t      pos_nxt;
	logic [TblAw:0] partner_sum;
	tbl_addr_t      partner;
	logic           warm_last;

	assign m_eff = (modulus_q == '0) ? (SeedW'(1) << ValW) : {1'b0, modulus_q};

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	// |seed_offset - |seed||, which the remainder unit reduces by the modulus
	assign seed_neg  = s_tdata[SeedW-1];
	assign need_seed = seed_neg || !seeded_q;
	assign seed_mag  = seed_neg ? (~s_tdata + SeedW'(1)) : s_tdata;
	assign seed_diff = {2'b00, seed_offset_q} - {1'b0, seed_mag};
	assign seed_abs  = seed_diff[SeedW] ? SeedW'(-seed_diff) : seed_diff[SeedW-1:0];

	// scatter position steps by 21 modulo 55
	assign pos_sum = {1'b0, pos_q} + (TblAw+1)'(ScatterStride);
	assign pos_nxt = (pos_sum >= (TblAw+1)'(TblDepth))
		? TblAw'(pos_sum - (TblAw+1)'(TblDepth)) : pos_sum[TblAw-1:0];

	// warm-up partner entry, 31 ahead modulo 55
	assign partner_sum = {1'b0, widx_q} + (TblAw+1)'(WarmLag);
	assign partner = (partner_sum >= (TblAw+1)'(TblDepth))
		? TblAw'(partner_sum - (TblAw+1)'(TblDepth)) : partner_sum[TblAw-1:0];
	assign warm_last = (widx_q == TblAw'(TblDepth - 1))
		&& (pass_q == WarmPassW'(WarmPasses - 1));

	// one difference path serves warm-up and draws
	assign tbl_diff = wrap_sub(rd_a, rd_b, m_eff);

	slrg_table u_table (
		.clk       (clk),
		.rd        (tbl_rd),
		.wr        (tbl_wr),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	slrg_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_xfer && need_seed),
		.dividend (seed_abs),
		.divisor  (m_eff),
		.stat     (mod_stat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer) begin
					state_nxt = need_seed ? ST_DIV : ST_DRAW_WB;
				end
			end
			ST_DIV: begin
				if (mod_stat.done) begin
					state_nxt = ST_SCATTER;
				end
			end
			ST_SCATTER: begin
				if (scat_cnt_q == TblAw'(TblDepth - 1)) begin
					state_nxt = ST_WARM;
				end
			end
			ST_WARM: begin
				if (warm_last) begin
					state_nxt = ST_DRAW_RD;
				end
			end
			ST_DRAW_RD: state_nxt = ST_DRAW_WB;
			ST_DRAW_WB: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// table accesses per state
	always_comb begin
		tbl_rd = '0;
		tbl_wr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer && !need_seed) begin
					tbl_rd.en     = 1'b1;
					tbl_rd.addr_a = ptr_next(rp_q) - TblAw'(1);
					tbl_rd.addr_b = ptr_next(lp_q) - TblAw'(1);
				end
			end
			ST_DIV: begin
				// last entry takes the reduced seed
				if (mod_stat.done) begin
					tbl_wr.en   = 1'b1;
					tbl_wr.addr = TblAw'(TblDepth - 1);
					tbl_wr.data = mod_stat.rem[ValW-1:0];
				end
			end
			ST_SCATTER: begin
				tbl_wr.en   = 1'b1;
				tbl_wr.addr = pos_q - TblAw'(1);
				tbl_wr.data = mk_q;
			end
			ST_WARM: begin
				tbl_rd.en     = 1'b1;
				tbl_rd.addr_a = widx_q;
				tbl_rd.addr_b = partner;
			end
			ST_DRAW_RD: begin
				tbl_rd.en     = 1'b1;
				tbl_rd.addr_a = ptr_next(rp_q) - TblAw'(1);
				tbl_rd.addr_b = ptr_next(lp_q) - TblAw'(1);
			end
			ST_DRAW_WB: begin
				if (out_free) begin
					tbl_wr.en   = 1'b1;
					tbl_wr.addr = rp_q - TblAw'(1);
					tbl_wr.data = tbl_diff;
				end
			end
			default: begin
				tbl_rd = '0;
				tbl_wr = '0;
			end
		endcase
		// warm-up write-back trails its read through warm_s1; the entry written
		// is never one read in the same cycle
		if (warm_s1) begin
			tbl_wr.en   = 1'b1;
			tbl_wr.addr = waddr_s1;
			tbl_wr.data = tbl_diff;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rp_q          <= '0;
			lp_q          <= TblAw'(LagStart);
			seeded_q      <= 1'b0;
			reseed_q      <= 1'b0;
			warm_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
			modulus_q     <= ModulusReset;
			seed_offset_q <= SeedOffsetReset;
		end else begin
			state_q <= state_nxt;
			warm_s1 <= (state_q == ST_WARM);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MODULUS:     modulus_q     <= cfg_data;
					CFG_SEED_OFFSET: seed_offset_q <= cfg_data;
					default:         modulus_q     <= modulus_q;
				endcase
			end

			if (s_xfer) begin
				reseed_q <= need_seed;
			end

			// rebuild restarts both ring pointers
			if (state_q == ST_DIV && mod_stat.done) begin
				rp_q     <= '0;
				lp_q     <= TblAw'(LagStart);
				seeded_q <= 1'b1;
			end else if (tbl_rd.en && state_q != ST_WARM) begin
				rp_q <= ptr_next(rp_q);
				lp_q <= ptr_next(lp_q);
			end

			if (state_q == ST_DRAW_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// rebuild and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && mod_stat.done) begin
			mj_q       <= mod_stat.rem[ValW-1:0];
			mk_q       <= ValW'(1);
			pos_q      <= TblAw'(ScatterStride);
			scat_cnt_q <= TblAw'(1);
		end else if (state_q == ST_SCATTER) begin
			mk_q       <= wrap_sub(mj_q, mk_q, m_eff);
			mj_q       <= mk_q;
			pos_q      <= pos_nxt;
			scat_cnt_q <= scat_cnt_q + TblAw'(1);
		end

		if (state_q == ST_SCATTER) begin
			widx_q <= '0;
			pass_q <= '0;
		end else if (state_q == ST_WARM) begin
			if (widx_q == TblAw'(TblDepth - 1)) begin
				widx_q <= '0;
				pass_q <= pass_q + WarmPassW'(1);
			end else begin
				widx_q <= widx_q + TblAw'(1);
			end
		end
		waddr_s1 <= widx_q;

		if (state_q == ST_DRAW_WB && out_free) begin
			out_value_q  <= tbl_diff;
			out_reseed_q <= reseed_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = SeedW'(out_value_q);
	assign m_tuser  = out_reseed_q;

	// lag pointer stays 31 ahead of the read pointer around the ring
	`SLRG_ASSERT_SAME(a_lag_gap_lo, rp_q <= TblAw'(TblDepth - LagStart), lp_q == rp_q + TblAw'(LagStart))
	`SLRG_ASSERT_SAME(a_lag_gap_hi, rp_q > TblAw'(TblDepth - LagStart), lp_q == rp_q - TblAw'(TblDepth - LagStart))
	// a rebuild in progress always reports itself
	`SLRG_ASSERT_SAME(a_rebuild_flag, state_q == ST_DIV || state_q == ST_SCATTER || state_q == ST_WARM || state_q == ST_DRAW_RD, reseed_q)
	// a plain draw reaches write-back right after its accept
	`SLRG_ASSERT_NEXT(a_draw_fast, s_xfer && !need_seed, state_q == ST_DRAW_WB)
	// write-back with room always presents a result
	`SLRG_ASSERT_NEXT(a_wb_result, state_q == ST_DRAW_WB && out_free, m_tvalid)

endmodule

`default_nettype wire
